// File: hdl/spfc_pkg.sv
// Shared types and constants for the switch panel frame controller.
`default_nettype none

package spfc_pkg;

    localparam int FRAME_LEN = 10;
    localparam int CNT_W     = $clog2(FRAME_LEN + 1);
    localparam int HDR_LEN   = 4;
    localparam int CMD_POS   = 4;
    localparam int DATA_POS  = 5;
    localparam int DATA_LEN  = 4;
    localparam int REPLY_LEN = 5;
    localparam int REPLY_W   = $clog2(REPLY_LEN);
    localparam int SW_W      = 4;
    localparam int COLOR_W   = 24;

    localparam logic [7:0] HDR_A      = 8'hCC;
    localparam logic [7:0] HDR_B      = 8'hAA;
    localparam logic [7:0] REPLY_TAIL = 8'h00;
    localparam logic [7:0] SW_ON      = 8'h01;
    localparam logic [7:0] SW_OFF     = 8'h00;

    localparam logic [COLOR_W-1:0] ON_COLOR_RST  = 24'hFFA500;
    localparam logic [COLOR_W-1:0] OFF_COLOR_RST = 24'h0000FF;

    typedef enum logic [1:0] {
        CMD_BYTE    = 2'd0,
        CMD_BUTTON  = 2'd1,
        CMD_TIMEOUT = 2'd2,
        CMD_NONE    = 2'd3
    } in_cmd_t;

    typedef enum logic [7:0] {
        FCMD_SWITCH    = 8'h01,
        FCMD_ON_COLOR  = 8'h02,
        FCMD_OFF_COLOR = 8'h03
    } frame_cmd_t;

    typedef enum logic [2:0] {
        OP_BUTTON,
        OP_SWITCH,
        OP_ON_COLOR,
        OP_OFF_COLOR,
        OP_REPLY_ONLY
    } job_op_t;

    typedef enum logic {
        BK_IDLE,
        BK_REPLY
    } back_state_t;

    typedef enum logic [REPLY_W-1:0] {
        RPL_XOR   = 3'd0,
        RPL_CHECK = 3'd1,
        RPL_HDR_A = 3'd2,
        RPL_HDR_B = 3'd3,
        RPL_TAIL  = 3'd4
    } reply_idx_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rx_byte;
        logic [3:0] buttons;
    } item_t;

    typedef struct packed {
        logic               kind;
        logic [7:0]         reply_byte;
        logic               reply_last;
        logic [SW_W-1:0]    switches;
        logic [COLOR_W-1:0] on_duty;
        logic [COLOR_W-1:0] off_duty;
    } result_t;

    // Byte 5 sits in the top byte of data, byte 8 in the bottom one.
    typedef struct packed {
        job_op_t                 op;
        logic [3:0]              buttons;
        logic [8*DATA_LEN-1:0]   data;
        logic [7:0]              x;
        logic [7:0]              check;
    } job_t;

endpackage

`default_nettype wire

// File: hdl/switch_panel_frame_controller.sv
// Top level of the switch panel frame controller.
//
//  Channel   Direction  Handshake              Word
//  input     in         push / full            item   (cmd, rx_byte, buttons)
//  result    out        pop / empty            result (kind, reply_byte, reply_last,
//                                                      switches, on_duty, off_duty)
//
// One input word is taken per cycle while full is low; the front end keeps a
// running XOR and byte count, so a frame is checked on its last byte or on a timeout.
// A button word gives its status word through the job and result queues; a frame
// with a good header is applied by the back end and then answered with 5 reply bytes.
// The job queue absorbs frame bursts; full rises only when it fills.
// Reset clears the frame, switches and press latch and loads the default colours.
`default_nettype none

module switch_panel_frame_controller #(
    parameter int CHANNELS  = 4,
    parameter int JOB_DEPTH = 4,
    parameter int RES_DEPTH = 2
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               push,
    input  spfc_pkg::item_t   item,
    output logic              full,
    input  wire               pop,
    output spfc_pkg::result_t result,
    output logic              empty
);

    spfc_pkg::job_t    job_in, job_out;
    spfc_pkg::result_t res_in;
    logic              job_push, job_full, job_pop, job_empty;
    logic              res_push, res_full;

    spfc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (full),
        .job_push (job_push),
        .job      (job_in),
        .job_full (job_full)
    );

    spfc_fifo #(
        .ELEM_T (spfc_pkg::job_t),
        .DEPTH  (JOB_DEPTH)
    ) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (job_in),
        .full  (job_full),
        .pop   (job_pop),
        .rdata (job_out),
        .empty (job_empty)
    );

    spfc_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job_out),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .res_push  (res_push),
        .res       (res_in),
        .res_full  (res_full)
    );

    spfc_fifo #(
        .ELEM_T (spfc_pkg::result_t),
        .DEPTH  (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

`default_nettype wire

// File: hdl/spfc_fifo.sv
// Small register queue used between the front, the back and the result port.
`default_nettype none

module spfc_fifo #(
    parameter type ELEM_T = logic,
    parameter int  DEPTH  = 4
) (
    input  wire   clk,
    input  wire   rst_n,
    input  wire   push,
    input  ELEM_T wdata,
    output logic  full,
    input  wire   pop,
    output ELEM_T rdata,
    output logic  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ELEM_T          mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// File: hdl/spfc_front.sv
// Front end: gathers frame bytes, checks header and check byte, issues jobs.
`default_nettype none

module spfc_front (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             push,
    input  spfc_pkg::item_t item,
    output logic            full,
    output logic            job_push,
    output spfc_pkg::job_t  job,
    input  wire             job_full
);

    localparam int DW = 8 * spfc_pkg::DATA_LEN;

    logic [spfc_pkg::CNT_W-1:0] count_reg, count_next;
    logic                       hdr_reg, hdr_next;
    logic [7:0]                 xor_reg, xor_next;
    logic [7:0]                 cmd_reg, cmd_next;
    logic [DW-1:0]              data_reg, data_next;

    logic       accept;
    logic       is_byte, is_button, is_timeout;
    logic       last_byte, evaluate, hdr_ok, check_ok;
    logic [7:0] check_byte;
    logic [7:0] hdr_expect;
    int         slot;

    assign full       = job_full;
    assign accept     = push && !job_full;
    assign is_byte    = (item.cmd == spfc_pkg::CMD_BYTE);
    assign is_button  = (item.cmd == spfc_pkg::CMD_BUTTON);
    assign is_timeout = (item.cmd == spfc_pkg::CMD_TIMEOUT);
    assign last_byte  = is_byte && (count_reg == spfc_pkg::CNT_W'(spfc_pkg::FRAME_LEN - 1));
    assign evaluate   = accept && (last_byte || is_timeout);

    // Missing bytes count as zero, so a frame shorter than the header fails the header check.
    assign hdr_ok     = hdr_reg && (count_reg >= spfc_pkg::CNT_W'(spfc_pkg::HDR_LEN));
    assign check_byte = last_byte ? item.rx_byte : 8'h00;
    assign check_ok   = (check_byte == xor_reg);
    assign hdr_expect = count_reg[0] ? spfc_pkg::HDR_B : spfc_pkg::HDR_A;

    always_comb
    begin
        job.buttons = item.buttons;
        job.data    = data_reg;
        job.x       = xor_reg;
        job.check   = check_byte;
        if (is_button)
        begin
            job.op = spfc_pkg::OP_BUTTON;
        end
        else if (!check_ok)
        begin
            job.op = spfc_pkg::OP_REPLY_ONLY;
        end
        else
        begin
            unique case (cmd_reg)
                spfc_pkg::FCMD_SWITCH:    job.op = spfc_pkg::OP_SWITCH;
                spfc_pkg::FCMD_ON_COLOR:  job.op = spfc_pkg::OP_ON_COLOR;
                spfc_pkg::FCMD_OFF_COLOR: job.op = spfc_pkg::OP_OFF_COLOR;
                default:                  job.op = spfc_pkg::OP_REPLY_ONLY;
            endcase
        end
        job_push = accept && (is_button || (evaluate && hdr_ok));
    end

    always_comb
    begin
        count_next = count_reg;
        hdr_next   = hdr_reg;
        xor_next   = xor_reg;
        cmd_next   = cmd_reg;
        data_next  = data_reg;
        slot       = int'(count_reg) - spfc_pkg::DATA_POS;
        if (evaluate)
        begin
            // Drop the frame after evaluation.
            count_next = '0;
            hdr_next   = 1'b1;
            xor_next   = '0;
            cmd_next   = '0;
            data_next  = '0;
        end
        else if (accept && is_byte)
        begin
            count_next = count_reg + 1'b1;
            xor_next   = xor_reg ^ item.rx_byte;
            if (count_reg < spfc_pkg::CNT_W'(spfc_pkg::HDR_LEN))
            begin
                hdr_next = hdr_reg && (item.rx_byte == hdr_expect);
            end
            if (count_reg == spfc_pkg::CNT_W'(spfc_pkg::CMD_POS))
            begin
                cmd_next = item.rx_byte;
            end
            for (int i = 0; i < spfc_pkg::DATA_LEN; i++)
            begin
                if (slot == i)
                begin
                    data_next[DW-1-8*i -: 8] = item.rx_byte;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            hdr_reg   <= 1'b1;
            xor_reg   <= '0;
            cmd_reg   <= '0;
            data_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            hdr_reg   <= hdr_next;
            xor_reg   <= xor_next;
            cmd_reg   <= cmd_next;
            data_reg  <= data_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/spfc_back.sv
// Back end: owns switch and colour state, executes jobs, emits result words.
`default_nettype none

module spfc_back #(
    parameter int CHANNELS = 4
) (
    input  wire               clk,
    input  wire               rst_n,
    input  spfc_pkg::job_t    job,
    input  wire               job_empty,
    output logic              job_pop,
    output logic              res_push,
    output spfc_pkg::result_t res,
    input  wire               res_full
);

    localparam int SW_W  = spfc_pkg::SW_W;
    localparam int LIVE  = (CHANNELS < SW_W) ? CHANNELS : SW_W;
    localparam int DW    = 8 * spfc_pkg::DATA_LEN;
    localparam logic [SW_W-1:0] CH_MASK = SW_W'((1 << LIVE) - 1);

    spfc_pkg::back_state_t        state_reg, state_next;
    logic [spfc_pkg::REPLY_W-1:0] idx_reg, idx_next;
    logic [SW_W-1:0]              sw_reg, latch_reg;
    logic [spfc_pkg::COLOR_W-1:0] on_reg, off_reg;
    logic [7:0]                   x_reg, check_reg;

    logic                         job_is_button;
    logic                         apply;
    logic                         reply_done;
    logic [SW_W-1:0]              sw_btn, latch_btn, sw_cmd;
    logic [SW_W-1:0]              sw_out;
    logic [7:0]                   reply_byte;

    assign job_is_button = (job.op == spfc_pkg::OP_BUTTON);
    assign reply_done    = (idx_reg == spfc_pkg::REPLY_W'(spfc_pkg::RPL_TAIL));

    // Toggle on a press edge, track levels in the latch.
    assign sw_btn    = (sw_reg ^ (job.buttons & ~latch_reg)) & CH_MASK;
    assign latch_btn = job.buttons & CH_MASK;

    always_comb
    begin
        sw_cmd = sw_reg;
        for (int i = 0; i < LIVE; i++)
        begin
            if (job.data[DW-1-8*i -: 8] == spfc_pkg::SW_ON)
            begin
                sw_cmd[i] = 1'b1;
            end
            else if (job.data[DW-1-8*i -: 8] == spfc_pkg::SW_OFF)
            begin
                sw_cmd[i] = 1'b0;
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spfc_pkg::BK_IDLE:
            begin
                if (!job_empty && !job_is_button)
                begin
                    state_next = spfc_pkg::BK_REPLY;
                end
            end
            spfc_pkg::BK_REPLY:
            begin
                if (!res_full && reply_done)
                begin
                    state_next = spfc_pkg::BK_IDLE;
                end
            end
            default: state_next = spfc_pkg::BK_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        job_pop  = 1'b0;
        res_push = 1'b0;
        apply    = 1'b0;
        sw_out   = sw_reg;
        unique case (state_reg)
            spfc_pkg::BK_IDLE:
            begin
                if (!job_empty)
                begin
                    if (job_is_button)
                    begin
                        job_pop  = !res_full;
                        res_push = !res_full;
                        sw_out   = sw_btn;
                    end
                    else
                    begin
                        job_pop = 1'b1;
                        apply   = 1'b1;
                    end
                end
            end
            spfc_pkg::BK_REPLY:
            begin
                res_push = !res_full;
            end
            default:
            begin
                res_push = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        unique case (idx_reg)
            spfc_pkg::RPL_XOR:   reply_byte = x_reg;
            spfc_pkg::RPL_CHECK: reply_byte = check_reg;
            spfc_pkg::RPL_HDR_A: reply_byte = spfc_pkg::HDR_A;
            spfc_pkg::RPL_HDR_B: reply_byte = spfc_pkg::HDR_B;
            spfc_pkg::RPL_TAIL:  reply_byte = spfc_pkg::REPLY_TAIL;
            default:             reply_byte = spfc_pkg::REPLY_TAIL;
        endcase
    end

    always_comb
    begin
        res.kind       = (state_reg == spfc_pkg::BK_IDLE);
        res.reply_byte = (state_reg == spfc_pkg::BK_IDLE) ? 8'h00 : reply_byte;
        res.reply_last = (state_reg == spfc_pkg::BK_REPLY) && reply_done;
        res.switches   = sw_out;
        res.on_duty    = ~on_reg;
        res.off_duty   = ~off_reg;
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (apply)
        begin
            idx_next = '0;
        end
        else if (state_reg == spfc_pkg::BK_REPLY && res_push)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spfc_pkg::BK_IDLE;
            idx_reg   <= '0;
            sw_reg    <= '0;
            latch_reg <= '0;
            on_reg    <= spfc_pkg::ON_COLOR_RST;
            off_reg   <= spfc_pkg::OFF_COLOR_RST;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (job_pop && job_is_button)
            begin
                sw_reg    <= sw_btn;
                latch_reg <= latch_btn;
            end
            if (apply)
            begin
                unique case (job.op)
                    spfc_pkg::OP_SWITCH:    sw_reg  <= sw_cmd;
                    spfc_pkg::OP_ON_COLOR:  on_reg  <= job.data[DW-1 -: spfc_pkg::COLOR_W];
                    spfc_pkg::OP_OFF_COLOR: off_reg <= job.data[DW-1 -: spfc_pkg::COLOR_W];
                    default:                sw_reg  <= sw_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (apply)
        begin
            x_reg     <= job.x;
            check_reg <= job.check;
        end
    end

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result word pushed into a full queue");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> !job_empty)
        else $error("job taken from an empty queue");

    a_reply_end: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.reply_last) |=> (state_reg == spfc_pkg::BK_IDLE))
        else $error("reply did not end after its last byte");

    a_reply_start: assert property (@(posedge clk) disable iff (!rst_n)
        apply |=> (state_reg == spfc_pkg::BK_REPLY && idx_reg == '0))
        else $error("reply did not start at its first byte");

endmodule

`default_nettype wire

// File: dv/switch_panel_frame_controller_tb.sv
// Self-checking testbench for the switch panel frame controller.
`timescale 1ns / 100ps

module switch_panel_frame_controller_tb;

    localparam int LIMIT = 200000;
    localparam int RANDOM_ITEMS = 500;

    typedef logic [spfc_pkg::FRAME_LEN-1:0][7:0] frame_t;

    logic              clk;
    logic              rst_n;
    logic              push;
    spfc_pkg::item_t   item;
    logic              full;
    logic              pop;
    spfc_pkg::result_t result;
    logic              empty;

    // predicted panel state
    logic [7:0]                   frame_buf [spfc_pkg::FRAME_LEN];
    int                           frame_cnt;
    logic [spfc_pkg::SW_W-1:0]    sw_state;
    logic [spfc_pkg::SW_W-1:0]    press_seen;
    logic [spfc_pkg::COLOR_W-1:0] on_col;
    logic [spfc_pkg::COLOR_W-1:0] off_col;

    spfc_pkg::result_t expected_words [$];
    int                errors;
    int                words_sent;
    int                cycles;
    bit                steady;

    switch_panel_frame_controller uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .full   (full),
        .pop    (pop),
        .result (result),
        .empty  (empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("switch_panel_frame_controller_tb: errors");
        $finish;
    end

    task automatic report(input string msg);
        $display("%0t: %s", $time, msg);
        errors++;
    endtask

    function automatic spfc_pkg::result_t status_word(input logic k, input logic [7:0] b,
                                                      input logic last);
        spfc_pkg::result_t r;
        r.kind       = k;
        r.reply_byte = b;
        r.reply_last = last;
        r.switches   = sw_state;
        r.on_duty    = ~on_col;
        r.off_duty   = ~off_col;
        return r;
    endfunction

    task automatic close_frame;
        logic [7:0]                   x;
        logic [spfc_pkg::COLOR_W-1:0] col;
        int                           i;
        x = 8'h00;
        for (i = 0; i < 9; i++)
            x ^= frame_buf[i];
        col = {frame_buf[spfc_pkg::DATA_POS], frame_buf[spfc_pkg::DATA_POS+1],
               frame_buf[spfc_pkg::DATA_POS+2]};
        if (frame_buf[0] == spfc_pkg::HDR_A && frame_buf[1] == spfc_pkg::HDR_B &&
            frame_buf[2] == spfc_pkg::HDR_A && frame_buf[3] == spfc_pkg::HDR_B)
        begin
            if (frame_buf[spfc_pkg::FRAME_LEN-1] == x)
            begin
                case (frame_buf[spfc_pkg::CMD_POS])
                    spfc_pkg::FCMD_SWITCH:
                    begin
                        for (i = 0; i < spfc_pkg::SW_W; i++)
                        begin
                            if (frame_buf[spfc_pkg::DATA_POS+i] == spfc_pkg::SW_ON)
                                sw_state[i] = 1'b1;
                            else if (frame_buf[spfc_pkg::DATA_POS+i] == spfc_pkg::SW_OFF)
                                sw_state[i] = 1'b0;
                        end
                    end
                    spfc_pkg::FCMD_ON_COLOR:  on_col = col;
                    spfc_pkg::FCMD_OFF_COLOR: off_col = col;
                    default: ;
                endcase
            end
            expected_words.push_back(status_word(1'b0, x, 1'b0));
            expected_words.push_back(status_word(1'b0, frame_buf[spfc_pkg::FRAME_LEN-1],
                                                 1'b0));
            expected_words.push_back(status_word(1'b0, spfc_pkg::HDR_A, 1'b0));
            expected_words.push_back(status_word(1'b0, spfc_pkg::HDR_B, 1'b0));
            expected_words.push_back(status_word(1'b0, spfc_pkg::REPLY_TAIL, 1'b1));
        end
        for (i = 0; i < spfc_pkg::FRAME_LEN; i++)
            frame_buf[i] = 8'h00;
        frame_cnt = 0;
    endtask

    task automatic panel_step(input spfc_pkg::item_t w);
        int i;
        case (w.cmd)
            spfc_pkg::CMD_BYTE:
            begin
                frame_buf[frame_cnt] = w.rx_byte;
                frame_cnt++;
                if (frame_cnt >= spfc_pkg::FRAME_LEN)
                    close_frame();
            end
            spfc_pkg::CMD_BUTTON:
            begin
                for (i = 0; i < spfc_pkg::SW_W; i++)
                begin
                    if (w.buttons[i])
                    begin
                        if (!press_seen[i])
                        begin
                            sw_state[i]   = ~sw_state[i];
                            press_seen[i] = 1'b1;
                        end
                    end
                    else
                        press_seen[i] = 1'b0;
                end
                expected_words.push_back(status_word(1'b1, 8'h00, 1'b0));
            end
            spfc_pkg::CMD_TIMEOUT: close_frame();
            default: ;
        endcase
    endtask

    task automatic compare_word(input spfc_pkg::result_t got);
        spfc_pkg::result_t want;
        if (expected_words.size() == 0)
        begin
            report($sformatf("unexpected word %h", got));
            return;
        end
        want = expected_words.pop_front();
        if (got.kind != want.kind)
            report($sformatf("kind %0d, want %0d", got.kind, want.kind));
        if (got.reply_byte != want.reply_byte)
            report($sformatf("reply_byte %h, want %h", got.reply_byte, want.reply_byte));
        if (got.reply_last != want.reply_last)
            report($sformatf("reply_last %0d, want %0d", got.reply_last, want.reply_last));
        if (got.switches != want.switches)
            report($sformatf("switches %b, want %b", got.switches, want.switches));
        if (got.on_duty != want.on_duty)
            report($sformatf("on_duty %h, want %h", got.on_duty, want.on_duty));
        if (got.off_duty != want.off_duty)
            report($sformatf("off_duty %h, want %h", got.off_duty, want.off_duty));
    endtask

    // check at the edge, then decide the next stall
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            compare_word(result);
        if (steady)
            pop <= 1'b1;
        else
            pop <= ($urandom_range(0, 99) >= 32);
    end

    task automatic send_word(input spfc_pkg::item_t w);
        if (!steady)
        begin
            while ($urandom_range(0, 99) < 32)
            begin
                push <= 1'b0;
                @(posedge clk);
            end
        end
        push <= 1'b1;
        item <= w;
        do
            @(posedge clk);
        while (full);
        panel_step(w);
        if (w.cmd != spfc_pkg::CMD_NONE)
            words_sent++;
    endtask

    function automatic spfc_pkg::item_t make_item(input spfc_pkg::in_cmd_t c,
                                                  input logic [7:0] b,
                                                  input logic [3:0] btn);
        spfc_pkg::item_t w;
        w.cmd     = c;
        w.rx_byte = b;
        w.buttons = btn;
        return w;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        send_word(make_item(spfc_pkg::CMD_BYTE, b, 4'($urandom)));
    endtask

    task automatic send_timeout;
        send_word(make_item(spfc_pkg::CMD_TIMEOUT, 8'($urandom), 4'($urandom)));
    endtask

    task automatic send_buttons(input logic [3:0] btn);
        send_word(make_item(spfc_pkg::CMD_BUTTON, 8'($urandom), btn));
    endtask

    // send the first len bytes; a short frame is closed by a timeout
    task automatic send_frame(input frame_t f, input int len, input int button_pct);
        int i;
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < button_pct)
                send_buttons(4'($urandom));
            send_byte(f[i]);
        end
        if (len < spfc_pkg::FRAME_LEN)
            send_timeout();
    endtask

    function automatic frame_t build_frame(input logic [7:0] op, input logic [31:0] data);
        frame_t f;
        logic [7:0] x;
        int i;
        f[0] = spfc_pkg::HDR_A;
        f[1] = spfc_pkg::HDR_B;
        f[2] = spfc_pkg::HDR_A;
        f[3] = spfc_pkg::HDR_B;
        f[spfc_pkg::CMD_POS] = op;
        for (i = 0; i < spfc_pkg::DATA_LEN; i++)
            f[spfc_pkg::DATA_POS+i] = data[31-8*i -: 8];
        x = 8'h00;
        for (i = 0; i < 9; i++)
            x ^= f[i];
        f[spfc_pkg::FRAME_LEN-1] = x;
        return f;
    endfunction

    task automatic wait_drain;
        push <= 1'b0;
        do
            @(posedge clk);
        while (expected_words.size() != 0);
    endtask

    task automatic test_buttons;
        send_buttons(4'hF);
        send_buttons(4'hF);
        send_buttons(4'h0);
    endtask

    task automatic test_ignored_and_empty_timeout;
        send_word(make_item(spfc_pkg::CMD_NONE, 8'hFF, 4'hF));
        send_timeout();
    endtask

    task automatic test_switch_frame;
        send_frame(build_frame(spfc_pkg::FCMD_SWITCH,
                               {spfc_pkg::SW_ON, spfc_pkg::SW_OFF, spfc_pkg::SW_ON, 8'h7F}),
                   spfc_pkg::FRAME_LEN, 0);
    endtask

    // header and command, header only, one byte: check byte reads as zero
    task automatic test_short_frames;
        frame_t f;
        f = build_frame(spfc_pkg::FCMD_OFF_COLOR, 32'h0);
        send_frame(f, spfc_pkg::CMD_POS + 1, 0);
        f = build_frame(8'h00, 32'h0);
        send_frame(f, spfc_pkg::CMD_POS, 0);
        send_byte(spfc_pkg::HDR_A);
        send_timeout();
    endtask

    function automatic logic [7:0] pick_data_byte;
        case ($urandom_range(0, 3))
            0: return spfc_pkg::SW_OFF;
            1: return spfc_pkg::SW_ON;
            2: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic test_random;
        frame_t     f;
        logic [7:0] op;
        int         r;
        int         len;
        int         start;
        bit         drained;
        start   = words_sent;
        drained = 1'b0;
        while (words_sent - start < RANDOM_ITEMS)
        begin
            steady = (words_sent - start >= 200 && words_sent - start < 300);
            if (!drained && words_sent - start >= 350)
            begin
                wait_drain();
                drained = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                if (frame_cnt != 0)
                    send_timeout();
                case ($urandom_range(0, 5))
                    0, 1, 5: op = spfc_pkg::FCMD_SWITCH;
                    2:       op = spfc_pkg::FCMD_ON_COLOR;
                    3:       op = spfc_pkg::FCMD_OFF_COLOR;
                    default: op = 8'($urandom);
                endcase
                f = build_frame(op, {pick_data_byte(), pick_data_byte(),
                                     pick_data_byte(), pick_data_byte()});
                if ($urandom_range(0, 99) < 15)
                    f[spfc_pkg::FRAME_LEN-1] = 8'($urandom);
                if ($urandom_range(0, 99) < 10)
                    f[$urandom_range(0, spfc_pkg::HDR_LEN-1)] ^= 8'($urandom_range(1, 255));
                len = ($urandom_range(0, 99) < 80) ? spfc_pkg::FRAME_LEN
                                                   : $urandom_range(1, 9);
                send_frame(f, len, 10);
            end
            else if (r < 80)
                send_buttons(4'($urandom));
            else if (r < 93)
                send_byte(8'($urandom));
            else if (r < 97)
                send_timeout();
            else
                send_word(make_item(spfc_pkg::CMD_NONE, 8'($urandom), 4'($urandom)));
        end
        steady = 1'b0;
    endtask

    initial
    begin
        int i;
        rst_n      = 1'b0;
        push       = 1'b0;
        item       = '0;
        pop        = 1'b0;
        steady     = 1'b0;
        errors     = 0;
        words_sent = 0;
        for (i = 0; i < spfc_pkg::FRAME_LEN; i++)
            frame_buf[i] = 8'h00;
        frame_cnt  = 0;
        sw_state   = '0;
        press_seen = '0;
        on_col     = spfc_pkg::ON_COLOR_RST;
        off_col    = spfc_pkg::OFF_COLOR_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_buttons();
        test_ignored_and_empty_timeout();
        test_switch_frame();
        test_short_frames();
        wait_drain();
        test_random();

        wait_drain();
        // let any stray word show up before closing
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("switch_panel_frame_controller_tb: clean");
        else
            $display("switch_panel_frame_controller_tb: errors");
        $finish;
    end

endmodule

// File: files.f
hdl/spfc_pkg.sv
hdl/spfc_fifo.sv
hdl/spfc_front.sv
hdl/spfc_back.sv
hdl/switch_panel_frame_controller.sv
dv/switch_panel_frame_controller_tb.sv
